// ----- hdl/ps2a_pkg.sv -----
// ============================================================================
// ps2a_pkg
// Types, make codes and character tables shared by the scan code translator.
// ============================================================================
package ps2a_pkg;

	localparam int unsigned CODE_W = 8;
	localparam int unsigned MAKE_W = 7;
	localparam int unsigned ROM_AW = 6;

	// Set 1 make codes of the keys that are handled specially.
	localparam logic [MAKE_W-1:0] MK_LSHIFT = 7'h2A;
	localparam logic [MAKE_W-1:0] MK_RSHIFT = 7'h36;
	localparam logic [MAKE_W-1:0] MK_LCTRL  = 7'h1D;
	localparam logic [MAKE_W-1:0] MK_LALT   = 7'h38;
	localparam logic [MAKE_W-1:0] MK_CAPS   = 7'h3A;

	// Bytes sent to the keyboard controller and prefix characters.
	localparam logic [7:0] CMD_SET_LEDS = 8'hED;
	localparam logic [7:0] LED_CAPS     = 8'h04;
	localparam logic [7:0] LED_NONE     = 8'h00;
	localparam logic [7:0] CHAR_CARET   = 8'h5E;
	localparam logic [7:0] CHAR_TILDE   = 8'h7E;

	// One unit of work for the back end: either an LED update or a character
	// with its modifier prefixes.
	typedef struct packed {
		logic       caps;
		logic       led_on;
		logic       ctrl;
		logic       alt;
		logic [7:0] ch;
	} job_t;

	function automatic logic is_letter(input logic [ROM_AW-1:0] mk);
		is_letter = mk inside {[6'h10:6'h19], [6'h1E:6'h26], [6'h2C:6'h32]};
	endfunction

	function automatic logic [7:0] rom_plain(input logic [ROM_AW-1:0] mk);
		case (mk)
			6'h01: rom_plain = 8'h1B;
			6'h02: rom_plain = 8'h31;
			6'h03: rom_plain = 8'h32;
			6'h04: rom_plain = 8'h33;
			6'h05: rom_plain = 8'h34;
			6'h06: rom_plain = 8'h35;
			6'h07: rom_plain = 8'h36;
			6'h08: rom_plain = 8'h37;
			6'h09: rom_plain = 8'h38;
			6'h0A: rom_plain = 8'h39;
			6'h0B: rom_plain = 8'h30;
			6'h0C: rom_plain = 8'h2D;
			6'h0D: rom_plain = 8'h3D;
			6'h0E: rom_plain = 8'h08;
			6'h0F: rom_plain = 8'h09;
			6'h10: rom_plain = 8'h71;
			6'h11: rom_plain = 8'h77;
			6'h12: rom_plain = 8'h65;
			6'h13: rom_plain = 8'h72;
			6'h14: rom_plain = 8'h74;
			6'h15: rom_plain = 8'h79;
			6'h16: rom_plain = 8'h75;
			6'h17: rom_plain = 8'h69;
			6'h18: rom_plain = 8'h6F;
			6'h19: rom_plain = 8'h70;
			6'h1A: rom_plain = 8'h5B;
			6'h1B: rom_plain = 8'h5D;
			6'h1C: rom_plain = 8'h0A;
			6'h1E: rom_plain = 8'h61;
			6'h1F: rom_plain = 8'h73;
			6'h20: rom_plain = 8'h64;
			6'h21: rom_plain = 8'h66;
			6'h22: rom_plain = 8'h67;
			6'h23: rom_plain = 8'h68;
			6'h24: rom_plain = 8'h6A;
			6'h25: rom_plain = 8'h6B;
			6'h26: rom_plain = 8'h6C;
			6'h27: rom_plain = 8'h3B;
			6'h28: rom_plain = 8'h27;
			6'h29: rom_plain = 8'h60;
			6'h2B: rom_plain = 8'h5C;
			6'h2C: rom_plain = 8'h7A;
			6'h2D: rom_plain = 8'h78;
			6'h2E: rom_plain = 8'h63;
			6'h2F: rom_plain = 8'h76;
			6'h30: rom_plain = 8'h62;
			6'h31: rom_plain = 8'h6E;
			6'h32: rom_plain = 8'h6D;
			6'h33: rom_plain = 8'h2C;
			6'h34: rom_plain = 8'h2E;
			6'h35: rom_plain = 8'h2F;
			6'h39: rom_plain = 8'h20;
			default: rom_plain = 8'h00;
		endcase
	endfunction

	function automatic logic [7:0] rom_shifted(input logic [ROM_AW-1:0] mk);
		case (mk)
			6'h01: rom_shifted = 8'h1B;
			6'h02: rom_shifted = 8'h21;
			6'h03: rom_shifted = 8'h40;
			6'h04: rom_shifted = 8'h23;
			6'h05: rom_shifted = 8'h24;
			6'h06: rom_shifted = 8'h25;
			6'h07: rom_shifted = 8'h5E;
			6'h08: rom_shifted = 8'h26;
			6'h09: rom_shifted = 8'h2A;
			6'h0A: rom_shifted = 8'h28;
			6'h0B: rom_shifted = 8'h29;
			6'h0C: rom_shifted = 8'h5F;
			6'h0D: rom_shifted = 8'h2B;
			6'h0E: rom_shifted = 8'h08;
			6'h0F: rom_shifted = 8'h09;
			6'h10: rom_shifted = 8'h51;
			6'h11: rom_shifted = 8'h57;
			6'h12: rom_shifted = 8'h45;
			6'h13: rom_shifted = 8'h52;
			6'h14: rom_shifted = 8'h54;
			6'h15: rom_shifted = 8'h59;
			6'h16: rom_shifted = 8'h55;
			6'h17: rom_shifted = 8'h49;
			6'h18: rom_shifted = 8'h4F;
			6'h19: rom_shifted = 8'h50;
			6'h1A: rom_shifted = 8'h7B;
			6'h1B: rom_shifted = 8'h7D;
			6'h1C: rom_shifted = 8'h0A;
			6'h1E: rom_shifted = 8'h41;
			6'h1F: rom_shifted = 8'h53;
			6'h20: rom_shifted = 8'h44;
			6'h21: rom_shifted = 8'h46;
			6'h22: rom_shifted = 8'h47;
			6'h23: rom_shifted = 8'h48;
			6'h24: rom_shifted = 8'h4A;
			6'h25: rom_shifted = 8'h4B;
			6'h26: rom_shifted = 8'h4C;
			6'h27: rom_shifted = 8'h3A;
			6'h28: rom_shifted = 8'h22;
			6'h29: rom_shifted = 8'h7E;
			6'h2B: rom_shifted = 8'h7C;
			6'h2C: rom_shifted = 8'h5A;
			6'h2D: rom_shifted = 8'h58;
			6'h2E: rom_shifted = 8'h43;
			6'h2F: rom_shifted = 8'h56;
			6'h30: rom_shifted = 8'h42;
			6'h31: rom_shifted = 8'h4E;
			6'h32: rom_shifted = 8'h4D;
			6'h33: rom_shifted = 8'h3C;
			6'h34: rom_shifted = 8'h3E;
			6'h35: rom_shifted = 8'h3F;
			6'h39: rom_shifted = 8'h20;
			default: rom_shifted = 8'h00;
		endcase
	endfunction

endpackage

// ----- hdl/ps2a_if.sv -----
// ============================================================================
// ps2a_if
// Valid/ready channels for scan codes in and translated bytes out.
// ============================================================================
interface ps2a_scan_if;
	logic       valid;
	logic       ready;
	logic [7:0] scan_code;

	modport source (output valid, output scan_code, input ready);
	modport sink   (input valid, input scan_code, output ready);
endinterface

interface ps2a_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       to_controller;
	logic       last;

	modport source (output valid, output out_byte, output to_controller, output last,
		input ready);
	modport sink   (input valid, input out_byte, input to_controller, input last,
		output ready);
endinterface

// ----- hdl/ps2a_front.sv -----
// ============================================================================
// ps2a_front
// Accepts scan codes, tracks the modifier flags and turns each press that
// produces output into a job for the back end.
// ============================================================================
module ps2a_front (
	input  logic            clk,
	input  logic            arst_n,
	ps2a_scan_if.sink       scan,
	output logic            job_valid,
	input  logic            job_ready,
	output ps2a_pkg::job_t  job
);

	logic                                shift_q;
	logic                                ctrl_q;
	logic                                alt_q;
	logic                                caps_q;
	logic                                shift_d;
	logic                                ctrl_d;
	logic                                alt_d;
	logic                                caps_d;
	logic                                pressed;
	logic [ps2a_pkg::MAKE_W-1:0]         mk;
	logic [ps2a_pkg::ROM_AW-1:0]         idx;
	logic                                eff_shift;
	logic [7:0]                          ch;
	logic                                has_job;
	logic                                accept;

	// A scan code is only taken when a job, should it make one, has room.
	assign scan.ready = job_ready;
	assign accept     = scan.valid & job_ready;

	assign pressed   = ~scan.scan_code[7];
	assign mk        = scan.scan_code[ps2a_pkg::MAKE_W-1:0];
	assign idx       = mk[ps2a_pkg::ROM_AW-1:0];
	assign eff_shift = shift_q ^ (ps2a_pkg::is_letter(idx) & caps_q);
	assign ch        = eff_shift ? ps2a_pkg::rom_shifted(idx) : ps2a_pkg::rom_plain(idx);

	always_comb begin
		shift_d    = shift_q;
		ctrl_d     = ctrl_q;
		alt_d      = alt_q;
		caps_d     = caps_q;
		has_job    = 1'b0;
		job.caps   = 1'b0;
		job.led_on = ~caps_q;
		job.ctrl   = ctrl_q;
		job.alt    = alt_q;
		job.ch     = ch;
		case (mk)
			ps2a_pkg::MK_LSHIFT, ps2a_pkg::MK_RSHIFT: begin
				shift_d = pressed;
			end
			ps2a_pkg::MK_LCTRL: begin
				ctrl_d = pressed;
			end
			ps2a_pkg::MK_LALT: begin
				alt_d = pressed;
			end
			ps2a_pkg::MK_CAPS: begin
				if (pressed) begin
					caps_d   = ~caps_q;
					has_job  = 1'b1;
					job.caps = 1'b1;
				end
			end
			default: begin
				// Make codes past the end of the tables give nothing.
				has_job = pressed & ~mk[ps2a_pkg::MAKE_W-1] & (ch != 8'h00);
			end
		endcase
	end

	assign job_valid = scan.valid & has_job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= 1'b0;
			ctrl_q  <= 1'b0;
			alt_q   <= 1'b0;
			caps_q  <= 1'b0;
		end else if (accept) begin
			shift_q <= shift_d;
			ctrl_q  <= ctrl_d;
			alt_q   <= alt_d;
			caps_q  <= caps_d;
		end
	end

endmodule

// ----- hdl/ps2a_queue.sv -----
// ============================================================================
// ps2a_queue
// Small first-in first-out queue of jobs between the front and back ends.
// ============================================================================
module ps2a_queue #(
	parameter int unsigned DEPTH = 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  ps2a_pkg::job_t  push_job,
	output logic            has_room,
	input  logic            pop,
	output logic            not_empty,
	output ps2a_pkg::job_t  head
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	ps2a_pkg::job_t     mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push;
	logic               do_pop;

	assign has_room  = (count_q != FULL_CNT);
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];
	assign do_push   = push & has_room;
	assign do_pop    = pop & not_empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- hdl/ps2a_back.sv -----
// ============================================================================
// ps2a_back
// Expands the job at the head of the queue into one to three output beats
// and holds each beat in an output register until it is taken.
// ============================================================================
module ps2a_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            job_valid,
	input  ps2a_pkg::job_t  job,
	output logic            job_pop,
	ps2a_out_if.source      result
);

	logic       valid_q;
	logic [7:0] byte_q;
	logic       ctl_q;
	logic       last_q;
	logic [1:0] step_q;
	logic [1:0] final_step;
	logic [1:0] alt_step;
	logic [7:0] beat_byte;
	logic       beat_last;
	logic       load;

	assign alt_step   = {1'b0, job.ctrl};
	assign final_step = job.caps ? 2'd1 : (2'({1'b0, job.ctrl}) + 2'({1'b0, job.alt}));
	assign beat_last  = (step_q == final_step);

	always_comb begin
		if (job.caps) begin
			if (step_q == 2'd0) begin
				beat_byte = ps2a_pkg::CMD_SET_LEDS;
			end else begin
				beat_byte = job.led_on ? ps2a_pkg::LED_CAPS : ps2a_pkg::LED_NONE;
			end
		end else if (job.ctrl && step_q == 2'd0) begin
			beat_byte = ps2a_pkg::CHAR_CARET;
		end else if (job.alt && step_q == alt_step) begin
			beat_byte = ps2a_pkg::CHAR_TILDE;
		end else begin
			beat_byte = job.ch;
		end
	end

	assign load    = job_valid & (~valid_q | result.ready);
	assign job_pop = load & beat_last;

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= beat_byte;
			ctl_q  <= job.caps;
			last_q <= beat_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			step_q  <= 2'd0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
			end else if (result.ready) begin
				valid_q <= 1'b0;
			end
			if (load) begin
				step_q <= beat_last ? 2'd0 : step_q + 2'd1;
			end
		end
	end

	assign result.valid         = valid_q;
	assign result.out_byte      = byte_q;
	assign result.to_controller = ctl_q;
	assign result.last          = last_q;

endmodule

// ----- hdl/ps2_scancode_to_ascii_top.sv -----
// ============================================================================
// ps2_scancode_to_ascii_top
// PS/2 scan code set 1 to ASCII translator, US layout.
// ============================================================================
// Scan codes come in one per beat on the scan channel and translated bytes
// leave on the result channel. The front end takes a scan code in any cycle
// in which the job queue has room, updates the shift, ctrl, alt and
// caps-lock flags at once and, for a key press that produces output, queues
// one job. The back end turns the head job into its beats, one beat per
// cycle while the result channel is ready, through a single output register,
// so a scan code yields as many beats as it has results: one for a plain
// character, two for a caps-lock LED update or a character with one prefix,
// three for a character with both the ctrl and alt prefixes. Modifier
// presses, releases and unmapped keys are taken and produce nothing. The
// first beat of a scan code passes through the job queue and then the output
// register. While the back end still expands one job, the front end keeps
// taking scan codes as long as the queue has room.
// Controller beats (LED command 0xED followed by the mask) carry
// to_controller high; the final beat of every job carries last high.
// QUEUE_DEPTH sets how many jobs may wait between the two halves.
// ============================================================================
module ps2_scancode_to_ascii_top #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	ps2a_scan_if.sink    scan,
	ps2a_out_if.source   result
);

	// Handshake and payload between the front end and the queue.
	logic            push_valid;
	logic            push_room;
	ps2a_pkg::job_t  push_job;

	// Handshake and payload between the queue and the back end.
	logic            head_valid;
	logic            head_pop;
	ps2a_pkg::job_t  head_job;

	ps2a_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.scan      (scan),
		.job_valid (push_valid),
		.job_ready (push_room),
		.job       (push_job)
	);

	ps2a_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push_valid),
		.push_job  (push_job),
		.has_room  (push_room),
		.pop       (head_pop),
		.not_empty (head_valid),
		.head      (head_job)
	);

	ps2a_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (head_valid),
		.job       (head_job),
		.job_pop   (head_pop),
		.result    (result)
	);

endmodule
